// File: rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants of the chunk retransmit scheduler.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_IVL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IVL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FATAL_TO     = 3'd4;

  localparam logic [15:0] BASE_IVL_RST  = 16'd100;
  localparam logic [15:0] MAX_IVL_RST   = 16'd1000;
  localparam logic [15:0] FATAL_TO_RST  = 16'd30;
  localparam logic [15:0] AUTO_ID_RST   = 16'd1;

  localparam logic [9:0]  LAST_MS       = 10'd999;
  localparam logic [15:0] IDLE_SAT      = 16'hFFFF;
  localparam logic [15:0] BACKOFF_SECS  = 16'd10;
  localparam logic [7:0]  ACK_FLAG_OK   = 8'd1;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SEND      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_FATAL     = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic  start_id;
    logic  div_step;
    logic  div_done;
    logic  ack;
    logic  tick;
    logic  deactivate;
    logic  round_start;
    logic  walk_step;
    logic  load_out;
    kind_t out_kind;
  } crs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic active;
    logic too_large;
    logic div_more;
    logic tick_fire;
    logic delivered;
    logic fatal;
    logic pend_bit;
    logic pend_last;
    logic out_free;
  } crs_sts_t;

endpackage

// File: rtl/crs_if.sv
// ----------------------------------------------------------------------------
// crs_if
// Valid/ready channels of the chunk retransmit scheduler.
// ----------------------------------------------------------------------------
interface crs_in_if import crs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] ack_msg_id;
  logic [7:0]  ack_chunk_idx;
  logic [7:0]  ack_flags;

  modport source (output valid, mode, ack_msg_id, ack_chunk_idx, ack_flags,
                  input ready);
  modport sink   (input valid, mode, ack_msg_id, ack_chunk_idx, ack_flags,
                  output ready);
endinterface

interface crs_out_if import crs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] msg_id;
  logic [4:0]  chunk_idx;
  logic [5:0]  chunk_total;
  logic [10:0] chunk_bytes;
  logic        last;

  modport source (output valid, kind, msg_id, chunk_idx, chunk_total,
                  chunk_bytes, last, input ready);
  modport sink   (input valid, kind, msg_id, chunk_idx, chunk_total,
                  chunk_bytes, last, output ready);
endinterface

interface crs_cfg_if import crs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/crs_ctrl.sv
// ----------------------------------------------------------------------------
// crs_ctrl
// Sequencer: start, chunk count, round decision, chunk walk, single reports.
// ----------------------------------------------------------------------------
module crs_ctrl import crs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  mode_t    in_mode,
  output logic     in_ready,
  input  crs_sts_t sts,
  output crs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ROUND,
    S_WALK,
    S_REPORT
  } state_t;

  state_t state_r, state_nxt;
  kind_t  rep_kind_r, rep_kind_nxt;

  always_comb begin
    state_nxt    = state_r;
    rep_kind_nxt = rep_kind_r;
    cmd          = '0;
    cmd.out_kind = KIND_SEND;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            MODE_START: begin
              if (!sts.active) begin
                cmd.start_id = 1'b1;
                if (sts.too_large) begin
                  rep_kind_nxt = KIND_TOO_LARGE;
                  state_nxt    = S_REPORT;
                end else begin
                  state_nxt = S_DIV;
                end
              end
            end
            MODE_ACK: cmd.ack = 1'b1;
            MODE_TICK: begin
              if (sts.active) begin
                cmd.tick = 1'b1;
                if (sts.tick_fire) state_nxt = S_ROUND;
              end
            end
            MODE_STOP: cmd.deactivate = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (sts.div_more) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.div_done = 1'b1;
          state_nxt    = S_ROUND;
        end
      end
      S_ROUND: begin
        if (sts.delivered) begin
          cmd.deactivate = 1'b1;
          rep_kind_nxt   = KIND_DONE;
          state_nxt      = S_REPORT;
        end else if (sts.fatal) begin
          cmd.deactivate = 1'b1;
          rep_kind_nxt   = KIND_FATAL;
          state_nxt      = S_REPORT;
        end else begin
          cmd.round_start = 1'b1;
          state_nxt       = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.pend_bit) begin
          if (sts.out_free) begin
            cmd.load_out  = 1'b1;
            cmd.walk_step = 1'b1;
            if (sts.pend_last) state_nxt = S_IDLE;
          end
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = rep_kind_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rep_kind_r <= KIND_DONE;
    end else begin
      state_r    <= state_nxt;
      rep_kind_r <= rep_kind_nxt;
    end
  end

endmodule

// File: rtl/crs_dp.sv
// ----------------------------------------------------------------------------
// crs_dp
// Datapath: config registers, transfer state, timers, chunk walk, result reg.
// ----------------------------------------------------------------------------
module crs_dp import crs_pkg::*; #(
  parameter int MAX_CHUNK_COUNT = 32,
  parameter int CHUNK_BYTES     = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crs_cmd_t             cmd,
  output crs_sts_t             sts,
  input  logic [15:0]          ack_id,
  input  logic [7:0]           ack_idx,
  input  logic [7:0]           ack_flags,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output kind_t                out_kind,
  output logic [15:0]          out_id,
  output logic [4:0]           out_idx,
  output logic [5:0]           out_total,
  output logic [10:0]          out_bytes,
  output logic                 out_last
);

  localparam int IDX_W = (MAX_CHUNK_COUNT > 1) ? $clog2(MAX_CHUNK_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNK_COUNT + 1);
  localparam logic [16:0] MAX_BYTES = 17'(MAX_CHUNK_COUNT * CHUNK_BYTES);
  localparam logic [15:0] CB16      = 16'(CHUNK_BYTES);
  localparam logic [10:0] CB11      = 11'(CHUNK_BYTES);

  logic [15:0] manual_id_r, payload_len_r, base_ivl_r, max_ivl_r, fatal_to_r;

  logic                       active_r;
  logic [15:0]                cur_id_r, next_auto_r;
  logic [CNT_W-1:0]           chunks_r, div_cnt_r;
  logic [15:0]                rem_r;
  logic [10:0]                last_bytes_r;
  logic [9:0]                 millis_r;
  logic [15:0]                idle_r, countdown_r;
  logic [MAX_CHUNK_COUNT-1:0] conf_r, pend_r;
  logic [IDX_W-1:0]           idx_r;

  logic                       out_valid_r, out_last_r;
  kind_t                      out_kind_r;
  logic [15:0]                out_id_r;
  logic [4:0]                 out_idx_r;
  logic [5:0]                 out_total_r;
  logic [10:0]                out_bytes_r;

  logic [MAX_CHUNK_COUNT-1:0] mask, idx_hot, ack_hot;
  logic                       ack_ok, is_tail;
  logic [19:0]                backoff;
  logic [15:0]                wait_ms;
  logic [IDX_W+4:0]           idx_ext;
  logic [CNT_W+5:0]           tot_ext;

  always_comb begin
    for (int j = 0; j < MAX_CHUNK_COUNT; j++) begin
      mask[j]    = (CNT_W'(j) < chunks_r);
      idx_hot[j] = (idx_r == IDX_W'(j));
      ack_hot[j] = (ack_idx == 8'(j));
    end
  end

  assign ack_ok = active_r && (ack_flags == ACK_FLAG_OK) && (ack_id == cur_id_r) &&
                  (ack_idx < 8'(chunks_r)) && ((conf_r & ack_hot) == '0);

  // base + 10 * idle seconds, capped
  assign backoff = 20'(base_ivl_r) + {1'b0, idle_r, 3'b000} + {3'b000, idle_r, 1'b0};
  always_comb begin
    wait_ms = base_ivl_r;
    if (idle_r >= BACKOFF_SECS)
      wait_ms = (backoff < 20'(max_ivl_r)) ? backoff[15:0] : max_ivl_r;
  end

  assign is_tail = !((CNT_W'(idx_r) + CNT_W'(1)) < chunks_r);
  assign idx_ext = {5'b0, idx_r};
  assign tot_ext = {6'b0, chunks_r};

  assign sts.active    = active_r;
  assign sts.too_large = ({1'b0, payload_len_r} > MAX_BYTES);
  assign sts.div_more  = (rem_r > CB16);
  assign sts.tick_fire = (countdown_r <= 16'd1);
  assign sts.delivered = ((conf_r & mask) == mask);
  assign sts.fatal     = (idle_r >= fatal_to_r);
  assign sts.pend_bit  = pend_r[idx_r];
  assign sts.pend_last = ((pend_r & ~idx_hot) == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_id_r   <= '0;
      payload_len_r <= '0;
      base_ivl_r    <= BASE_IVL_RST;
      max_ivl_r     <= MAX_IVL_RST;
      fatal_to_r    <= FATAL_TO_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MANUAL_ID:   manual_id_r   <= cfg_data;
        REG_PAYLOAD_LEN: payload_len_r <= cfg_data;
        REG_BASE_IVL:    base_ivl_r    <= cfg_data;
        REG_MAX_IVL:     max_ivl_r     <= cfg_data;
        REG_FATAL_TO:    fatal_to_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      cur_id_r     <= '0;
      next_auto_r  <= AUTO_ID_RST;
      chunks_r     <= '0;
      div_cnt_r    <= '0;
      rem_r        <= '0;
      last_bytes_r <= '0;
      millis_r     <= '0;
      idle_r       <= '0;
      countdown_r  <= '0;
      conf_r       <= '0;
      pend_r       <= '0;
      idx_r        <= '0;
    end else begin
      if (cmd.start_id) begin
        if (manual_id_r != 16'd0) begin
          cur_id_r <= manual_id_r;
        end else begin
          cur_id_r    <= next_auto_r;
          next_auto_r <= next_auto_r + 16'd1;
        end
        rem_r     <= payload_len_r;
        div_cnt_r <= '0;
      end
      if (cmd.div_step) begin
        rem_r     <= rem_r - CB16;
        div_cnt_r <= div_cnt_r + CNT_W'(1);
      end
      if (cmd.div_done) begin
        chunks_r     <= div_cnt_r + CNT_W'(1);
        last_bytes_r <= rem_r[10:0];
        conf_r       <= '0;
        millis_r     <= '0;
        idle_r       <= '0;
        active_r     <= 1'b1;
      end
      if (cmd.ack && ack_ok) begin
        conf_r   <= conf_r | ack_hot;
        idle_r   <= '0;
        millis_r <= '0;
      end
      if (cmd.tick) begin
        if (millis_r == LAST_MS) begin
          millis_r <= '0;
          if (idle_r != IDLE_SAT) idle_r <= idle_r + 16'd1;
        end else begin
          millis_r <= millis_r + 10'd1;
        end
        countdown_r <= sts.tick_fire ? 16'd0 : countdown_r - 16'd1;
      end
      if (cmd.deactivate) active_r <= 1'b0;
      if (cmd.round_start) begin
        countdown_r <= wait_ms;
        pend_r      <= ~conf_r & mask;
        idx_r       <= '0;
      end
      if (cmd.walk_step) begin
        pend_r <= pend_r & ~idx_hot;
        idx_r  <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind_r <= cmd.out_kind;
      out_id_r   <= cur_id_r;
      if (cmd.out_kind == KIND_SEND) begin
        out_idx_r   <= idx_ext[4:0];
        out_total_r <= tot_ext[5:0];
        out_bytes_r <= is_tail ? last_bytes_r : CB11;
        out_last_r  <= sts.pend_last;
      end else begin
        out_idx_r   <= '0;
        out_total_r <= (cmd.out_kind == KIND_TOO_LARGE) ? 6'd0 : tot_ext[5:0];
        out_bytes_r <= '0;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_id    = out_id_r;
  assign out_idx   = out_idx_r;
  assign out_total = out_total_r;
  assign out_bytes = out_bytes_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/chunk_retransmit_scheduler_unit.sv
// Flow: ack, stop and idle ticks are taken in the idle state. A start counts
// chunks (N) in the divide state, then decides in the round state, then walks
// chunk indices up to the last unconfirmed one, one result per cycle at most,
// stalling while the result is not taken. A tick that opens a round starts
// there. The chunk walk over the confirmed bitmap sets the throughput (N <= 32).
// Reset (synchronous, active low) sets power-on values; result data is not reset.
// ----------------------------------------------------------------------------
// chunk_retransmit_scheduler_unit
// Selective-repeat sender: chunking, ack bitmap, round timer with backoff.
// ----------------------------------------------------------------------------
module chunk_retransmit_scheduler_unit import crs_pkg::*; #(
  parameter int MAX_CHUNK_COUNT = 32,
  parameter int CHUNK_BYTES     = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  crs_in_if.sink      in_chan,
  crs_out_if.source   out_chan,
  crs_cfg_if.sink     cfg_chan
);

  crs_cmd_t cmd;
  crs_sts_t sts;
  logic     in_ready;
  kind_t    out_kind;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  crs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_mode  (mode_t'(in_chan.mode)),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  crs_dp #(
    .MAX_CHUNK_COUNT (MAX_CHUNK_COUNT),
    .CHUNK_BYTES     (CHUNK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .ack_id    (in_chan.ack_msg_id),
    .ack_idx   (in_chan.ack_chunk_idx),
    .ack_flags (in_chan.ack_flags),
    .cfg_we    (cfg_chan.valid),
    .cfg_idx   (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_kind  (out_kind),
    .out_id    (out_chan.msg_id),
    .out_idx   (out_chan.chunk_idx),
    .out_total (out_chan.chunk_total),
    .out_bytes (out_chan.chunk_bytes),
    .out_last  (out_chan.last)
  );

  assign out_chan.kind = out_kind;

  // never overwrite a result that has not been transferred
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && (in_chan.mode == MODE_STOP) |=> !sts.active)
    else $error("transfer still active after stop");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && (in_chan.mode == MODE_TICK) && !sts.active
    |=> in_chan.ready)
    else $error("tick while inactive left the sequencer busy");

endmodule
